// ===== design/clnf_pkg.sv =====
// ============================================================================
// clnf_pkg - shared types and constants of the character LCD number formatter
// Request and result words, the job descriptor passed from the front end to
// the back end, operation codes, display byte constants and small helpers.
// ============================================================================
package clnf_pkg;

    // Default number of decimal digits kept by the BCD converter.
    localparam int MAX_DIGITS_DEF = 5;
    // Width of the binary value fed to the BCD converter.
    localparam int VALUE_W        = 16;
    // Depth of the job queue between front end and back end.
    localparam int QDEPTH         = 2;

    // Request operation codes.
    localparam logic [2:0] OP_INIT = 3'd0;
    localparam logic [2:0] OP_CHAR = 3'd1;
    localparam logic [2:0] OP_UDEC = 3'd2;
    localparam logic [2:0] OP_SDEC = 3'd3;
    localparam logic [2:0] OP_BIN  = 3'd4;
    localparam logic [2:0] OP_HEX  = 3'd5;

    // Display bytes.
    localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_DDRAM     = 8'h80;
    localparam logic [7:0] ROW2_OFFSET   = 8'h40;
    localparam logic [7:0] COL_MINUS_ONE = 8'hFF;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_A          = 8'h41;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_X          = 8'h58;

    // Request word.
    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  row;
        logic [4:0]  col;
        logic [15:0] value;
        logic [2:0]  digit_count;
        logic [7:0]  char_code;
    } t_req;

    // Result word.
    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } t_res;

    // Kind of body that the back end emits after the optional cursor command.
    typedef enum logic [2:0] {
        K_INIT,
        K_CHAR,
        K_UDEC,
        K_SDEC,
        K_BIN,
        K_HEX
    } t_kind;

    // Classified job; the decimal digits travel beside it.
    typedef struct packed {
        t_kind      kind;
        logic       cursor_en;
        logic [7:0] cursor_byte;
        logic [3:0] len;
        logic [7:0] ch;
        logic [7:0] lowb;
        logic       neg;
    } t_job;

    // ASCII for one uppercase hex digit.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib >= 4'd10) begin
            r = CH_A + {4'd0, nib} - 8'd10;
        end else begin
            r = CH_ZERO + {4'd0, nib};
        end
        return r;
    endfunction

    // The four setup commands of the init request, in order.
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = CMD_FUNC_SET;
            2'd1:    r = CMD_DISP_ON;
            2'd2:    r = CMD_ENTRY;
            default: r = CMD_CLEAR;
        endcase
        return r;
    endfunction

endpackage

// ===== design/clnf_front.sv =====
// ============================================================================
// clnf_front - request intake, classification and BCD conversion
// Takes a request word, turns it into a job descriptor and, for decimal
// requests, converts the magnitude to packed BCD by shift-and-add-3.
// ============================================================================
module clnf_front #(
    parameter int MAX_DIGITS = clnf_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  clnf_pkg::t_req              i_req,
    output logic                        o_busy,
    input  logic                        i_q_full,
    output logic                        o_push,
    output clnf_pkg::t_job              o_job,
    output logic [MAX_DIGITS-1:0][3:0]  o_bcd
);

    localparam int CNTW = $clog2(clnf_pkg::VALUE_W + 1);
    localparam int BCDW = MAX_DIGITS * 4;

    typedef enum logic {
        S_IDLE,
        S_CONV
    } t_state;

    t_state                         r_state;
    clnf_pkg::t_job                 r_job;
    logic [clnf_pkg::VALUE_W-1:0]   r_bin;
    logic [MAX_DIGITS-1:0][3:0]     r_bcd;
    logic [CNTW-1:0]                r_cnt;

    clnf_pkg::t_job                 n_job;
    logic [MAX_DIGITS-1:0][3:0]     n_bcd;
    logic [MAX_DIGITS-1:0][3:0]     adj;
    logic [clnf_pkg::VALUE_W-1:0]   mag;
    logic [2:0]                     ndig;
    logic                           accept;
    logic                           is_dec;
    logic                           conv_done;
    logic                           direct_push;

    assign accept    = i_start && !o_busy;
    assign o_busy    = (r_state != S_IDLE) || i_q_full;
    assign conv_done = (r_state == S_CONV) && (r_cnt == CNTW'(clnf_pkg::VALUE_W));

    // Classification of the incoming request.
    always_comb begin
        n_job             = '0;
        n_job.kind        = clnf_pkg::K_INIT;
        n_job.ch          = i_req.char_code;
        n_job.lowb        = i_req.value[7:0];
        n_job.neg         = (i_req.op == clnf_pkg::OP_SDEC) && i_req.value[15];
        n_job.cursor_en   = (i_req.op != clnf_pkg::OP_INIT) && (i_req.op <= clnf_pkg::OP_HEX)
                            && ((i_req.row == 2'd1) || (i_req.row == 2'd2));
        n_job.cursor_byte = clnf_pkg::CMD_DDRAM | ({3'd0, i_req.col}
                            + clnf_pkg::COL_MINUS_ONE
                            + ((i_req.row == 2'd2) ? clnf_pkg::ROW2_OFFSET : 8'd0));

        if ({1'b0, i_req.digit_count} > 4'(MAX_DIGITS)) begin
            ndig = 3'(MAX_DIGITS);
        end else begin
            ndig = i_req.digit_count;
        end

        case (i_req.op)
            clnf_pkg::OP_INIT: begin
                n_job.kind = clnf_pkg::K_INIT;
                n_job.len  = 4'd4;
            end
            clnf_pkg::OP_CHAR: begin
                n_job.kind = clnf_pkg::K_CHAR;
                n_job.len  = 4'd1;
            end
            clnf_pkg::OP_UDEC: begin
                n_job.kind = clnf_pkg::K_UDEC;
                n_job.len  = {1'b0, ndig};
            end
            clnf_pkg::OP_SDEC: begin
                n_job.kind = clnf_pkg::K_SDEC;
                n_job.len  = {1'b0, ndig} + 4'd1;
            end
            clnf_pkg::OP_BIN: begin
                n_job.kind = clnf_pkg::K_BIN;
                n_job.len  = 4'd8;
            end
            clnf_pkg::OP_HEX: begin
                n_job.kind = clnf_pkg::K_HEX;
                n_job.len  = 4'd4;
            end
            default: begin
                // Unused codes produce no writes at all.
                n_job.len       = 4'd0;
                n_job.cursor_en = 1'b0;
            end
        endcase

        is_dec = ((i_req.op == clnf_pkg::OP_UDEC) || (i_req.op == clnf_pkg::OP_SDEC))
                 && (ndig != 3'd0);
        mag    = n_job.neg ? (~i_req.value + 16'd1) : i_req.value;
    end

    // One shift-and-add-3 step; digits shifted out of the top are dropped,
    // which keeps the value modulo 10^MAX_DIGITS.
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            adj[d] = (r_bcd[d] >= 4'd5) ? (r_bcd[d] + 4'd3) : r_bcd[d];
        end
        n_bcd = BCDW'({adj, r_bin[clnf_pkg::VALUE_W-1]});
    end

    assign direct_push = accept && !is_dec && (n_job.cursor_en || (n_job.len != 4'd0));
    assign o_push      = direct_push || conv_done;
    assign o_job       = conv_done ? r_job : n_job;
    assign o_bcd       = conv_done ? r_bcd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && is_dec) begin
                        r_state <= S_CONV;
                        r_cnt   <= '0;
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end

        if (accept && is_dec) begin
            r_job <= n_job;
            r_bin <= mag;
            r_bcd <= '0;
        end else if ((r_state == S_CONV) && !conv_done) begin
            r_bin <= {r_bin[clnf_pkg::VALUE_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

endmodule

// ===== design/clnf_queue.sv =====
// ============================================================================
// clnf_queue - short job queue between front end and back end
// Holds classified jobs together with their decimal digits in order.
// ============================================================================
module clnf_queue #(
    parameter int MAX_DIGITS = clnf_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  clnf_pkg::t_job              i_job,
    input  logic [MAX_DIGITS-1:0][3:0]  i_bcd,
    input  logic                        i_pop,
    output logic                        o_full,
    output logic                        o_empty,
    output clnf_pkg::t_job              o_job,
    output logic [MAX_DIGITS-1:0][3:0]  o_bcd
);

    localparam int AW = (clnf_pkg::QDEPTH > 1) ? $clog2(clnf_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(clnf_pkg::QDEPTH + 1);

    clnf_pkg::t_job              r_job_q [clnf_pkg::QDEPTH];
    logic [MAX_DIGITS-1:0][3:0]  r_bcd_q [clnf_pkg::QDEPTH];
    logic [AW-1:0]               r_wptr;
    logic [AW-1:0]               r_rptr;
    logic [CW-1:0]               r_count;

    assign o_full  = (r_count == CW'(clnf_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_job_q[r_rptr];
    assign o_bcd   = r_bcd_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(clnf_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(clnf_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end

        if (i_push) begin
            r_job_q[r_wptr] <= i_job;
            r_bcd_q[r_wptr] <= i_bcd;
        end
    end

endmodule

// ===== design/clnf_back.sv =====
// ============================================================================
// clnf_back - display write sequencer
// Takes jobs from the queue and, while one is active, emits one registered
// bus word per cycle: optional cursor command, body bytes, last one marked.
// ============================================================================
module clnf_back #(
    parameter int MAX_DIGITS = clnf_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  clnf_pkg::t_job              i_job,
    input  logic [MAX_DIGITS-1:0][3:0]  i_bcd,
    output logic                        o_pop,
    output logic                        o_res_valid,
    output clnf_pkg::t_res              o_res
);

    localparam int KW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic                        r_active;
    logic                        r_cur_pend;
    logic [3:0]                  r_idx;
    clnf_pkg::t_job              r_job;
    logic [MAX_DIGITS-1:0][3:0]  r_bcd;
    logic                        r_valid;
    clnf_pkg::t_res              r_res;

    logic [3:0]                  k_full;
    logic [KW-1:0]               k;
    logic [7:0]                  body;
    clnf_pkg::t_res              n_res;
    logic                        done;

    always_comb begin
        // Digit position counted from the least significant digit.
        k_full = r_job.len - 4'd1 - r_idx;
        k      = k_full[KW-1:0];

        case (r_job.kind)
            clnf_pkg::K_INIT: body = clnf_pkg::init_byte(r_idx[1:0]);
            clnf_pkg::K_CHAR: body = r_job.ch;
            clnf_pkg::K_UDEC: body = clnf_pkg::CH_ZERO + {4'd0, r_bcd[k]};
            clnf_pkg::K_SDEC: begin
                if (r_idx == 4'd0) begin
                    body = r_job.neg ? clnf_pkg::CH_MINUS : clnf_pkg::CH_PLUS;
                end else begin
                    body = clnf_pkg::CH_ZERO + {4'd0, r_bcd[k]};
                end
            end
            clnf_pkg::K_BIN: body = clnf_pkg::CH_ZERO + {7'd0, r_job.lowb[3'(4'd7 - r_idx)]};
            clnf_pkg::K_HEX: begin
                case (r_idx[1:0])
                    2'd0:    body = clnf_pkg::CH_ZERO;
                    2'd1:    body = clnf_pkg::CH_X;
                    2'd2:    body = clnf_pkg::hex_char(r_job.lowb[7:4]);
                    default: body = clnf_pkg::hex_char(r_job.lowb[3:0]);
                endcase
            end
            default: body = clnf_pkg::CH_ZERO;
        endcase

        if (r_cur_pend) begin
            n_res.is_data  = 1'b0;
            n_res.bus_byte = r_job.cursor_byte;
            n_res.last     = (r_job.len == 4'd0);
        end else begin
            n_res.is_data  = (r_job.kind != clnf_pkg::K_INIT);
            n_res.bus_byte = body;
            n_res.last     = (r_idx == r_job.len - 4'd1);
        end
    end

    assign done        = r_active && n_res.last;
    assign o_pop       = !i_empty && (!r_active || done);
    assign o_res_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (done) begin
                r_active <= 1'b0;
            end
        end

        r_res <= n_res;
        if (o_pop) begin
            r_job      <= i_job;
            r_bcd      <= i_bcd;
            r_idx      <= '0;
            r_cur_pend <= i_job.cursor_en;
        end else if (r_active) begin
            if (r_cur_pend) begin
                r_cur_pend <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

endmodule

// ===== design/char_lcd_number_formatter_core.sv =====
// ============================================================================
// char_lcd_number_formatter_core - HD44780 write sequencer with formatting
// Turns each request into a run of display bus words (command or data bytes)
// for a character LCD, including decimal, binary and hex number formatting.
// ============================================================================
// A request is taken at a rising edge where i_start is high and o_busy is
// low. Each bus word appears on o_res for exactly one cycle, marked by
// o_res_valid, and must be captured then: the output side cannot be stalled.
// The last word of every request has o_res.last set. Init emits 0x38, 0x0C,
// 0x06 and 0x01; other requests emit a cursor command for row 1 or 2 and then
// a character, decimal digits (with a sign for the signed form), eight binary
// digits or "0X" and two hex digits. Unused op codes, and an unsigned decimal
// request with no digits and no cursor, produce no words at all. Words come
// out one per cycle while a job is being sent. A request that needs no
// conversion passes through the job queue, the back end's job register and
// its output register before its first word appears. Decimal requests first
// pass through the front-end BCD converter (one shift-and-add-3 step per bit
// of the 16-bit magnitude) before they are queued for the back end. The
// front end and back end are joined by a two-entry job queue, so a new
// request is taken while earlier words are still being sent; o_busy is high
// during a conversion and while the queue is full. A request emits up to
// nine words.
// ============================================================================
module char_lcd_number_formatter_core #(
    parameter int MAX_DIGITS = clnf_pkg::MAX_DIGITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  clnf_pkg::t_req  i_req,
    output logic            o_busy,
    output logic            o_res_valid,
    output clnf_pkg::t_res  o_res
);

    // Front end to queue.
    logic                        push;
    clnf_pkg::t_job              push_job;
    logic [MAX_DIGITS-1:0][3:0]  push_bcd;

    // Queue to back end.
    logic                        q_full;
    logic                        q_empty;
    logic                        pop;
    clnf_pkg::t_job              head_job;
    logic [MAX_DIGITS-1:0][3:0]  head_bcd;

    // Accepts requests, classifies them and converts decimal magnitudes.
    clnf_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job),
        .o_bcd    (push_bcd)
    );

    // Lets the front end take the next request while words are still going out.
    clnf_queue #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_bcd   (push_bcd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job),
        .o_bcd   (head_bcd)
    );

    // Emits the bus words of each job, one per cycle.
    clnf_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (head_job),
        .i_bcd       (head_bcd),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
